/* src/pmfd_pkg.sv */
`default_nettype none
package pmfd_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HEADER_0 = 8'h55;
  localparam logic [7:0] HEADER_1 = 8'h5A;

  localparam int MUL_A_W  = 64;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 96;
  localparam int DIV_D_W  = 32;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_COEFF = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_COEFF = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd2;

  localparam logic [31:0] COEFF_RESET   = 32'd65536;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_BREAK = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_HEADER   = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_V_CHK,
    S_V_MUL,
    S_V_DIV,
    S_I_CHK,
    S_I_MUL,
    S_I_DIV,
    S_P_CHK,
    S_P_MUL1,
    S_P_MUL2,
    S_P_DIV,
    S_APP_MUL,
    S_PF_CHK,
    S_PF_DIV,
    S_AE_MUL,
    S_SE_MUL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] voltage;
    logic [31:0] current;
    logic [31:0] real_pwr;
    logic [31:0] total_pwr;
    logic [17:0] pwr_ratio;
    logic [63:0] real_energy;
    logic [63:0] total_energy;
  } out_item_t;

  typedef struct packed {
    logic        header_ok;
    logic        checksum_ok;
    logic [2:0]  update;
    logic [23:0] voltage_param;
    logic [23:0] voltage_reg;
    logic [23:0] current_param;
    logic [23:0] current_reg;
    logic [23:0] power_param;
    logic [23:0] power_reg;
  } frame_t;

endpackage
`default_nettype wire

/* src/pmfd_frame.sv */
`default_nettype none
module pmfd_frame (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      data,
  input  logic            drop,
  output logic            last,
  output pmfd_pkg::frame_t frame
);
  import pmfd_pkg::*;

  logic [7:0]       fs [FRAME_BYTES];
  logic [POS_W-1:0] pos;
  logic [7:0]       sum;

  assign last = pos == POS_W'(FRAME_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (drop) begin
      pos <= '0;
    end else if (push) begin
      pos <= last ? '0 : pos + POS_W'(1);
    end
  end

  // oldest byte ends at index 0 once the frame is complete
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) fs[i] <= fs[i+1];
      fs[FRAME_BYTES-1] <= data;
      if (pos == '0) begin
        sum <= '0;
      end else if (pos >= POS_W'(2) && pos <= POS_W'(FRAME_BYTES - 2)) begin
        sum <= sum + data;
      end
    end
  end

  always_comb begin
    frame.header_ok     = fs[0] == HEADER_0 && fs[1] == HEADER_1;
    frame.checksum_ok   = sum == fs[FRAME_BYTES-1];
    frame.update        = fs[20][6:4];
    frame.voltage_param = {fs[2], fs[3], fs[4]};
    frame.voltage_reg   = {fs[5], fs[6], fs[7]};
    frame.current_param = {fs[8], fs[9], fs[10]};
    frame.current_reg   = {fs[11], fs[12], fs[13]};
    frame.power_param   = {fs[14], fs[15], fs[16]};
    frame.power_reg     = {fs[17], fs[18], fs[19]};
  end

endmodule
`default_nettype wire

/* src/pmfd_mul.sv */
`default_nettype none
module pmfd_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pmfd_pkg::MUL_A_W-1:0]  a,
  input  logic [pmfd_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [pmfd_pkg::PROD_W-1:0]   prod
);
  import pmfd_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0] a_hold;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [MUL_A_W:0]   sum;

  // one multiplier bit a cycle, shift right
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_hold} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      hi     <= '0;
      lo     <= b;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule
`default_nettype wire

/* src/pmfd_div.sv */
`default_nettype none
module pmfd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pmfd_pkg::DIV_N_W-1:0]  num,
  input  logic [pmfd_pkg::DIV_D_W-1:0]  den,
  output logic                          done,
  output logic [pmfd_pkg::DIV_D_W-1:0]  quo
);
  import pmfd_pkg::*;

  localparam int Q_W   = DIV_D_W;
  localparam int CNT_W = $clog2(Q_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0] den_hold;
  logic [DIV_D_W-1:0] rem;
  logic [Q_W-1:0]     lo;
  logic               over;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial = {rem, lo[Q_W-1]};
  assign diff  = trial - {1'b0, den_hold};
  assign ge    = trial >= {1'b0, den_hold};
  assign quo   = over ? '1 : lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient too wide for Q_W bits when the upper part already reaches den
  always_ff @(posedge clk) begin
    if (start) begin
      den_hold <= den;
      over     <= num[DIV_N_W-1:Q_W] >= {{(DIV_N_W - Q_W - DIV_D_W){1'b0}}, den};
      rem      <= num[Q_W+DIV_D_W-1:Q_W];
      lo       <= num[Q_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      lo  <= {lo[Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* src/power_meter_frame_decoder_core.sv */
`default_nettype none
// Channel  | Direction | Handshake         | Payload
// input    | in        | in_valid/in_stall | in_item  (operation, rx_byte)
// result   | out       | out_valid/out_stall | out_item (status, readings, energies)
// config   | in        | cfg_write         | cfg_index, cfg_data
//
// A data byte, break or tick is taken while in_stall is low. The last byte of a frame
// starts a computation on the shared bit-serial multiplier and divider (up to
// eleven operations per frame). Reset (synchronous) clears readings, energies and
// counters and loads the register defaults. in_stall is high while a frame is
// computed and while a result waits on out_stall.
module power_meter_frame_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pmfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pmfd_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pmfd_pkg::out_item_t                 out_item
);
  import pmfd_pkg::*;

  logic [31:0] v_coeff;
  logic [31:0] i_coeff;
  logic [15:0] timeout;

  state_t state, state_next;
  logic   go;

  logic [31:0] volt, volt_next;
  logic [31:0] curr, curr_next;
  logic [31:0] act, act_next;
  logic [31:0] app, app_next;
  logic [17:0] pf, pf_next;
  logic [63:0] ae, ae_next;
  logic [63:0] se, se_next;
  logic [31:0] ticks, ticks_next;
  logic [15:0] idle, idle_next;

  logic    accept;
  logic    emit;
  status_t emit_status;
  logic    push;
  logic    drop;
  logic    last;
  frame_t  frame;

  logic               is_mul;
  logic               is_div;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic               div_done;
  logic [DIV_D_W-1:0] div_quo;

  function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? '1 : s[63:0];
  endfunction

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  pmfd_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .data  (in_item.rx_byte),
    .drop  (drop),
    .last  (last),
    .frame (frame)
  );

  pmfd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (go && is_mul),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pmfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (go && is_div),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_coeff <= COEFF_RESET;
      i_coeff <= COEFF_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VOLTAGE_COEFF: v_coeff <= cfg_data;
        CFG_CURRENT_COEFF: i_coeff <= cfg_data;
        CFG_IDLE_TIMEOUT:  timeout <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
      volt  <= '0;
      curr  <= '0;
      act   <= '0;
      app   <= '0;
      pf    <= '0;
      ae    <= '0;
      se    <= '0;
      ticks <= '0;
      idle  <= '0;
    end else begin
      state <= state_next;
      go    <= state_next != state;
      volt  <= volt_next;
      curr  <= curr_next;
      act   <= act_next;
      app   <= app_next;
      pf    <= pf_next;
      ae    <= ae_next;
      se    <= se_next;
      ticks <= ticks_next;
      idle  <= idle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.status       <= emit_status;
      out_item.voltage      <= volt_next;
      out_item.current      <= curr_next;
      out_item.real_pwr     <= act_next;
      out_item.total_pwr    <= app_next;
      out_item.pwr_ratio    <= pf_next;
      out_item.real_energy  <= ae_next;
      out_item.total_energy <= se_next;
    end
  end

  always_comb begin
    state_next  = state;
    volt_next   = volt;
    curr_next   = curr;
    act_next    = act;
    app_next    = app;
    pf_next     = pf;
    ae_next     = ae;
    se_next     = se;
    ticks_next  = ticks;
    idle_next   = idle;
    emit        = 1'b0;
    emit_status = ST_OK;
    push        = 1'b0;
    drop        = 1'b0;
    is_mul      = 1'b0;
    is_div      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_num     = '0;
    div_den     = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_item.operation))
            OP_DATA: begin
              push      = 1'b1;
              idle_next = '0;
              if (last) state_next = S_CHECK;
            end
            OP_BREAK: begin
              volt_next   = '0;
              curr_next   = '0;
              act_next    = '0;
              app_next    = '0;
              pf_next     = '0;
              drop        = 1'b1;
              idle_next   = '0;
              emit        = 1'b1;
              emit_status = ST_CLEARED;
            end
            OP_TICK: begin
              if (idle != '1) idle_next = idle + 16'd1;
              if (ticks != '1) ticks_next = ticks + 32'd1;
              // fire once when the idle count reaches the timeout
              if (idle != '1 && idle == timeout) begin
                volt_next   = '0;
                curr_next   = '0;
                act_next    = '0;
                app_next    = '0;
                pf_next     = '0;
                drop        = 1'b1;
                emit        = 1'b1;
                emit_status = ST_CLEARED;
              end
            end
            OP_NONE: ;
          endcase
        end
      end
      S_CHECK: begin
        if (!frame.header_ok) begin
          emit        = 1'b1;
          emit_status = ST_HEADER;
          state_next  = S_IDLE;
        end else if (!frame.checksum_ok) begin
          emit        = 1'b1;
          emit_status = ST_CHECKSUM;
          state_next  = S_IDLE;
        end else begin
          state_next = S_V_CHK;
        end
      end
      S_V_CHK: begin
        if (!frame.update[2]) begin
          state_next = S_I_CHK;
        end else if (frame.voltage_reg == '0) begin
          volt_next  = '0;
          state_next = S_I_CHK;
        end else begin
          state_next = S_V_MUL;
        end
      end
      S_V_MUL: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(frame.voltage_param);
        mul_b  = v_coeff;
        if (mul_done) state_next = S_V_DIV;
      end
      S_V_DIV: begin
        is_div  = 1'b1;
        div_num = mul_prod;
        div_den = DIV_D_W'(frame.voltage_reg);
        if (div_done) begin
          volt_next  = div_quo;
          state_next = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (!frame.update[1]) begin
          state_next = S_P_CHK;
        end else if (frame.current_reg == '0) begin
          curr_next  = '0;
          state_next = S_P_CHK;
        end else begin
          state_next = S_I_MUL;
        end
      end
      S_I_MUL: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(frame.current_param);
        mul_b  = i_coeff;
        if (mul_done) state_next = S_I_DIV;
      end
      S_I_DIV: begin
        is_div  = 1'b1;
        div_num = mul_prod;
        div_den = DIV_D_W'(frame.current_reg);
        if (div_done) begin
          curr_next  = div_quo;
          state_next = S_P_CHK;
        end
      end
      S_P_CHK: begin
        if (!frame.update[0]) begin
          state_next = S_FINISH;
        end else if (frame.power_reg == '0) begin
          act_next   = '0;
          state_next = S_APP_MUL;
        end else begin
          state_next = S_P_MUL1;
        end
      end
      S_P_MUL1: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(frame.power_param);
        mul_b  = i_coeff;
        if (mul_done) state_next = S_P_MUL2;
      end
      S_P_MUL2: begin
        is_mul = 1'b1;
        mul_a  = mul_prod[MUL_A_W-1:0];
        mul_b  = v_coeff;
        if (mul_done) state_next = S_P_DIV;
      end
      S_P_DIV: begin
        // dividing by reg * 2^16 is the same as dropping 16 bits first
        is_div  = 1'b1;
        div_num = DIV_N_W'(mul_prod[PROD_W-1:16]);
        div_den = DIV_D_W'(frame.power_reg);
        if (div_done) begin
          act_next   = div_quo;
          state_next = S_APP_MUL;
        end
      end
      S_APP_MUL: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(volt);
        mul_b  = curr;
        if (mul_done) begin
          app_next   = (mul_prod[63:48] != '0) ? '1 : mul_prod[47:16];
          state_next = S_PF_CHK;
        end
      end
      S_PF_CHK: begin
        if (app == '0) begin
          pf_next    = '0;
          state_next = S_AE_MUL;
        end else begin
          state_next = S_PF_DIV;
        end
      end
      S_PF_DIV: begin
        is_div  = 1'b1;
        div_num = DIV_N_W'({act, 16'd0});
        div_den = app;
        if (div_done) begin
          pf_next    = (div_quo[31:18] != '0) ? '1 : div_quo[17:0];
          state_next = S_AE_MUL;
        end
      end
      S_AE_MUL: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(act);
        mul_b  = ticks;
        if (mul_done) begin
          ae_next    = add_sat(ae, mul_prod[63:0]);
          state_next = S_SE_MUL;
        end
      end
      S_SE_MUL: begin
        is_mul = 1'b1;
        mul_a  = MUL_A_W'(app);
        mul_b  = ticks;
        if (mul_done) begin
          se_next    = add_sat(se, mul_prod[63:0]);
          ticks_next = '0;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        emit        = 1'b1;
        emit_status = ST_OK;
        state_next  = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import pmfd_pkg::*;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  power_meter_frame_decoder_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // shadow of the block's registers and state
  logic [31:0] m_vcoeff, m_icoeff;
  logic [15:0] m_timeout;
  logic [7:0]  m_frame [FRAME_BYTES];
  int          m_pos;
  logic [31:0] m_volt, m_curr, m_active, m_apparent;
  logic [17:0] m_factor;
  logic [63:0] m_real_energy, m_total_energy;
  logic [31:0] m_ticks_since_power;
  logic [15:0] m_idle_ticks;

  out_item_t pending_readings [$];
  int mismatches;
  int results_seen;
  int items_sent;
  int frames_sent;

  // sender burst shaping
  int burst_left;
  int gap_len;

  // receiver
  logic hold_req;
  logic hold_active = 1'b0;
  int   stall_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout: %0d readings still pending", pending_readings.size());
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] sat32(logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [127:0] b);
    logic [127:0] s;
    s = {64'b0, a} + b;
    return (s > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [23:0] field24(int at);
    return {m_frame[at], m_frame[at+1], m_frame[at+2]};
  endfunction

  function automatic void clear_readings();
    m_volt = '0;
    m_curr = '0;
    m_active = '0;
    m_apparent = '0;
    m_factor = '0;
  endfunction

  function automatic out_item_t snapshot(status_t st);
    out_item_t r;
    r.status = st;
    r.voltage = m_volt;
    r.current = m_curr;
    r.real_pwr = m_active;
    r.total_pwr = m_apparent;
    r.pwr_ratio = m_factor;
    r.real_energy = m_real_energy;
    r.total_energy = m_total_energy;
    return r;
  endfunction

  function automatic status_t judge_frame();
    logic [7:0] sum;
    logic [7:0] upd;
    logic [23:0] rg;
    logic [127:0] app;
    sum = '0;
    if (m_frame[0] != HEADER_0 || m_frame[1] != HEADER_1) return ST_HEADER;
    for (int i = 2; i < 23; i++) sum += m_frame[i];
    if (sum != m_frame[23]) return ST_CHECKSUM;
    upd = m_frame[20];
    if (upd[6]) begin
      rg = field24(5);
      m_volt = (rg == 0) ? '0 : sat32((128'(field24(2)) * m_vcoeff) / rg);
    end
    if (upd[5]) begin
      rg = field24(11);
      m_curr = (rg == 0) ? '0 : sat32((128'(field24(8)) * m_icoeff) / rg);
    end
    if (upd[4]) begin
      rg = field24(17);
      m_active = (rg == 0) ? '0 :
        sat32((128'(field24(14)) * m_icoeff * m_vcoeff) / (128'(rg) << 16));
      app = (128'(m_volt) * m_curr) >> 16;
      m_apparent = sat32(app);
      if (m_apparent == 0) m_factor = '0;
      else begin
        app = (128'(m_active) << 16) / m_apparent;
        m_factor = (app > 128'h3FFFF) ? 18'h3FFFF : app[17:0];
      end
      m_real_energy = add_sat64(m_real_energy, 128'(m_active) * m_ticks_since_power);
      m_total_energy = add_sat64(m_total_energy,
                                 128'(m_apparent) * m_ticks_since_power);
      m_ticks_since_power = '0;
    end
    return ST_OK;
  endfunction

  // advance the shadow state by one accepted item
  function automatic void decode_item(in_item_t it);
    logic fire;
    case (it.operation)
      OP_DATA: begin
        m_idle_ticks = '0;
        m_frame[m_pos] = it.rx_byte;
        m_pos++;
        if (m_pos == FRAME_BYTES) begin
          m_pos = 0;
          pending_readings.push_back(snapshot(judge_frame()));
        end
      end
      OP_BREAK: begin
        clear_readings();
        m_pos = 0;
        m_idle_ticks = '0;
        pending_readings.push_back(snapshot(ST_CLEARED));
      end
      OP_TICK: begin
        fire = (m_idle_ticks != 16'hFFFF) && (m_idle_ticks == m_timeout);
        if (m_idle_ticks != 16'hFFFF) m_idle_ticks++;
        if (m_ticks_since_power != 32'hFFFF_FFFF) m_ticks_since_power++;
        if (fire) begin
          clear_readings();
          m_pos = 0;
          pending_readings.push_back(snapshot(ST_CLEARED));
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(op_t op, logic [7:0] b);
    in_item_t it;
    it.operation = op;
    it.rx_byte = b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_valid = 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    decode_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] fb [FRAME_BYTES]);
    for (int i = 0; i < FRAME_BYTES; i++) send_item(OP_DATA, fb[i]);
    frames_sent++;
  endtask

  // build a frame with random content; damage header or checksum on request
  function automatic void build_frame(output logic [7:0] fb [FRAME_BYTES],
                                      input bit bad_header, input bit bad_sum);
    logic [7:0] sum;
    sum = '0;
    fb[0] = HEADER_0;
    fb[1] = HEADER_1;
    for (int i = 2; i < 23; i++) fb[i] = 8'($urandom_range(0, 255));
    // keep regs mostly nonzero, some of them small
    for (int k = 5; k <= 17; k += 6) begin
      case ($urandom_range(0, 9))
        0: {fb[k], fb[k+1], fb[k+2]} = '0;
        1, 2: {fb[k], fb[k+1], fb[k+2]} = 24'($urandom_range(1, 255));
        default: begin
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) fb[20][6:4] = 3'b111;
    for (int i = 2; i < 23; i++) sum += fb[i];
    fb[23] = sum;
    if (bad_header) begin
      if ($urandom_range(0, 1)) fb[0] ^= 8'(1 << $urandom_range(0, 7));
      else fb[1] ^= 8'(1 << $urandom_range(0, 7));
    end
    if (bad_sum) fb[23] ^= 8'($urandom_range(1, 255));
  endfunction

  task automatic drain();
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_VOLTAGE_COEFF: m_vcoeff = val;
      CFG_CURRENT_COEFF: m_icoeff = val;
      CFG_IDLE_TIMEOUT: m_timeout = val[15:0];
      default: begin
      end
    endcase
  endtask

  function automatic void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s in reading %0d: expected %h, got %h",
               what, results_seen, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected reading %h", out_item);
      end else begin
        want = pending_readings.pop_front();
        if (out_item.status !== want.status)
          report("status", 64'(want.status), 64'(out_item.status));
        if (out_item.voltage !== want.voltage)
          report("voltage", 64'(want.voltage), 64'(out_item.voltage));
        if (out_item.current !== want.current)
          report("current", 64'(want.current), 64'(out_item.current));
        if (out_item.real_pwr !== want.real_pwr)
          report("real power", 64'(want.real_pwr), 64'(out_item.real_pwr));
        if (out_item.total_pwr !== want.total_pwr)
          report("total power", 64'(want.total_pwr), 64'(out_item.total_pwr));
        if (out_item.pwr_ratio !== want.pwr_ratio)
          report("power ratio", 64'(want.pwr_ratio), 64'(out_item.pwr_ratio));
        if (out_item.real_energy !== want.real_energy)
          report("real energy", want.real_energy, out_item.real_energy);
        if (out_item.total_energy !== want.total_energy)
          report("total energy", want.total_energy, out_item.total_energy);
      end
      results_seen++;
    end
  end

  // long hold-off, counted here
  always @(negedge clk) begin
    int hold_count;
    if (hold_req && !hold_active) begin
      hold_active <= 1'b1;
      hold_count = 3000;
    end else if (hold_active) begin
      hold_count--;
      if (hold_count == 0) hold_active <= 1'b0;
    end
  end

  // receiver stall pattern: switch between calm, light and heavy stretches
  always @(negedge clk) begin
    int mode_left;
    logic pat;
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      0: pat = 1'b0;
      1: pat = ($urandom_range(0, 3) == 0);
      default: pat = ($urandom_range(0, 3) != 0);
    endcase
    out_stall <= rst ? 1'b0 : (pat | hold_active);
  end

  task automatic test_directed();
    logic [7:0] fb [FRAME_BYTES];
    // largest params, smallest regs: voltage, current and power readings saturate
    build_frame(fb, 0, 0);
    for (int i = 2; i < 20; i++) fb[i] = 8'hFF;
    fb[5] = 0; fb[6] = 0; fb[7] = 1;
    fb[11] = 0; fb[12] = 0; fb[13] = 1;
    fb[17] = 0; fb[18] = 0; fb[19] = 1;
    fb[20] = 8'hFF; fb[21] = 8'h00; fb[22] = 8'h00;
    fb[23] = '0;
    for (int i = 2; i < 23; i++) fb[23] += fb[i];
    send_item(OP_TICK, 8'h00);
    send_frame(fb);
    // zero regs give zero readings
    fb[7] = 0; fb[13] = 0; fb[19] = 0;
    fb[23] -= 8'd3;
    send_frame(fb);
    // update bits clear: readings hold
    build_frame(fb, 0, 0);
    fb[23] -= fb[20];
    fb[20] = 8'h00;
    send_frame(fb);
    build_frame(fb, 1, 0);
    send_frame(fb);
    build_frame(fb, 0, 1);
    send_frame(fb);
    // break in the middle of a frame, then two unused operations
    build_frame(fb, 0, 0);
    for (int i = 0; i < 10; i++) send_item(OP_DATA, fb[i]);
    send_item(OP_BREAK, 8'hFF);
    send_item(OP_NONE, 8'hA5);
    send_item(OP_NONE, 8'h5A);
    send_frame(fb);
  endtask

  task automatic test_timeout();
    write_reg(CFG_IDLE_TIMEOUT, 32'd0);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    write_reg(CFG_IDLE_TIMEOUT, 32'd3);
    send_item(OP_DATA, HEADER_0);
    repeat (6) send_item(OP_TICK, 8'h00);
    write_reg(CFG_IDLE_TIMEOUT, 32'hFFFF);
    repeat (20) send_item(OP_TICK, 8'h00);
  endtask

  task automatic test_coeff_extremes();
    logic [7:0] fb [FRAME_BYTES];
    logic [31:0] pick [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001};
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_VOLTAGE_COEFF, pick[i]);
      write_reg(CFG_CURRENT_COEFF, pick[3 - i]);
      build_frame(fb, 0, 0);
      send_frame(fb);
    end
  endtask

  task automatic test_random(int target);
    logic [7:0] fb [FRAME_BYTES];
    while (items_sent < target) begin
      if (($urandom_range(0, 19) == 0)) begin
        write_reg(CFG_VOLTAGE_COEFF, $urandom_range(0, 3) == 0 ? $urandom() :
                                     $urandom_range(1, 32'h0004_0000));
        write_reg(CFG_CURRENT_COEFF, $urandom_range(0, 3) == 0 ? $urandom() :
                                     $urandom_range(1, 32'h0004_0000));
        write_reg(CFG_IDLE_TIMEOUT, $urandom_range(0, 1) ? $urandom_range(0, 30) :
                                    $urandom_range(0, 65535));
      end
      case ($urandom_range(0, 19))
        0: send_item(OP_BREAK, 8'($urandom_range(0, 255)));
        1: repeat ($urandom_range(1, 40)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
        2: send_item(OP_NONE, 8'($urandom_range(0, 255)));
        3: begin
          // noise bytes, then a break to realign
          repeat ($urandom_range(1, 30)) send_item(OP_DATA, 8'($urandom_range(0, 255)));
          send_item(OP_BREAK, 8'h00);
        end
        default: begin
          build_frame(fb, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
          if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5))
            send_item(OP_TICK, 8'h00);
          send_frame(fb);
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] fb [FRAME_BYTES];
    hold_req = 1'b1;
    wait (hold_active);
    hold_req = 1'b0;
    repeat (3) begin
      build_frame(fb, 0, 0);
      send_frame(fb);
    end
    send_item(OP_BREAK, 8'h00);
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_VOLTAGE_COEFF;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    hold_req = 1'b0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    frames_sent = 0;
    burst_left = 0;
    m_vcoeff = COEFF_RESET;
    m_icoeff = COEFF_RESET;
    m_timeout = TIMEOUT_RESET;
    m_pos = 0;
    clear_readings();
    m_real_energy = '0;
    m_total_energy = '0;
    m_ticks_since_power = '0;
    m_idle_ticks = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_timeout();
    test_coeff_extremes();
    test_backpressure();
    test_random(1950);

    in_valid = 1'b0;
    wait_cycles = 0;
    while (pending_readings.size() != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (500) @(negedge clk);
    $display("Sent %0d items (%0d frames) through breaks, ticks, timeouts and stalls;",
             items_sent, frames_sent);
    $display("checked %0d readings, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* power_meter_frame_decoder_core.f */
src/pmfd_pkg.sv
src/pmfd_frame.sv
src/pmfd_mul.sv
src/pmfd_div.sv
src/power_meter_frame_decoder_core.sv
test/tb_top.sv
